// ===== hdl/fcw_pkg.sv =====
// Package for the FAT12 cluster chain walker.
// Holds field widths, reset values, command and register codes and state types.
// No dependencies; every other file of the block but fcw_ram imports it.
package fcw_pkg;

    localparam int unsigned FCW_FAT_SIZE_BYTES = 4096;

    localparam int unsigned KIND_W     = 2;
    localparam int unsigned FAT_IDX_W  = 12;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CLUSTER_W  = 12;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned ADDR_W     = 28;
    localparam int unsigned CHUNK_W    = 16;
    localparam int unsigned FAT_BYTES_W = 13;
    localparam int unsigned BASE_W     = 24;
    localparam int unsigned POS_W      = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CHUNK_W-1:0]     RST_CLUSTER_BYTES = 16'd2048;
    localparam logic [FAT_BYTES_W-1:0] RST_FAT_BYTES     = 13'd512;
    localparam logic [BASE_W-1:0]      RST_DATA_BASE     = 24'd2048;

    typedef enum logic [KIND_W-1:0] {
        KIND_FAT_WRITE = 2'd0,
        KIND_START     = 2'd1,
        KIND_NEXT      = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLUSTER_BYTES = 2'd0,
        CFG_FAT_BYTES     = 2'd1,
        CFG_DATA_BASE     = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH0 = 4'b0010,
        S_FETCH1 = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        RT_CHUNK = 2'd0,
        RT_ERROR = 2'd1,
        RT_EMPTY = 2'd2
    } t_rtype;

endpackage

// ===== hdl/fcw_cmd_if.sv =====
// Command channel of the FAT12 cluster chain walker.
// Carries valid, ready and the command fields; depends on fcw_pkg.
interface fcw_cmd_if import fcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [FAT_IDX_W-1:0] fat_index;
    logic [BYTE_W-1:0]    fat_byte;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [LEN_W-1:0]     file_length;

    modport source (output valid, kind, fat_index, fat_byte, start_cluster, file_length,
                    input ready);
    modport sink (input valid, kind, fat_index, fat_byte, start_cluster, file_length,
                  output ready);
endinterface

// ===== hdl/fcw_chunk_if.sv =====
// Chunk result channel of the FAT12 cluster chain walker.
// Carries valid, ready and the chunk fields; depends on fcw_pkg.
interface fcw_chunk_if import fcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  image_addr;
    logic [CHUNK_W-1:0] chunk_len;
    logic [LEN_W-1:0]   file_offset;
    logic               last;
    logic               error;

    modport source (output valid, image_addr, chunk_len, file_offset, last, error,
                    input ready);
    modport sink (input valid, image_addr, chunk_len, file_offset, last, error,
                  output ready);
endinterface

// ===== hdl/fcw_ram.sv =====
// Generic single-port-per-direction RAM with a registered read.
// One write port and one read port; no dependencies.
module fcw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/fat12_cluster_chain_walker_unit.sv =====
// Walks a FAT12 cluster chain held in an on-chip table RAM, one chunk per start or next
// command. A FAT byte write or an unused command is taken without leaving the idle state.
// A start or next command passes from acceptance through the check step, which checks the
// cluster, forms the data offset product and issues the first read of the table RAM, the
// second read step through its single read port, and the deliver step into the output
// register; the command port accepts again once the walker is back in the idle state. An
// empty-file answer or a next command without an active walk goes straight to the deliver
// step, and a chain error found by the cluster check goes from the check step to it. Any
// result waits in the deliver step while the output register is still full. A new command
// is accepted while a finished result still waits in the output register. No clearing pass
// is needed after reset. Depends on fcw_pkg, fcw_cmd_if, fcw_chunk_if and fcw_ram.
module fat12_cluster_chain_walker_unit import fcw_pkg::*; #(
    parameter int unsigned FAT_SIZE_BYTES = FCW_FAT_SIZE_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fcw_cmd_if.sink               i_cmd,
    fcw_chunk_if.source           o_chunk
);
    localparam int unsigned AW = $clog2(FAT_SIZE_BYTES);

    logic [CHUNK_W-1:0]     r_cluster_bytes;
    logic [FAT_BYTES_W-1:0] r_fat_bytes;
    logic [BASE_W-1:0]      r_data_base;

    t_state               r_state, n_state;
    logic                 r_walk_active, n_walk_active;
    logic                 r_out_valid, n_out_valid;
    logic [CLUSTER_W-1:0] r_cur_cluster, n_cur_cluster;
    logic [LEN_W-1:0]     r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0]     r_done_bytes, n_done_bytes;

    t_rtype             r_rtype, n_rtype;
    logic [ADDR_W-1:0]  r_prod;
    logic [ADDR_W-1:0]  r_addr;
    logic [CHUNK_W-1:0] r_len;
    logic [BYTE_W-1:0]  r_byte0;
    logic               r_zero0;
    logic               r_zero1;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [CHUNK_W-1:0] r_o_len;
    logic [LEN_W-1:0]   r_o_off;
    logic               r_o_last;
    logic               r_o_error;

    logic                 in_fire;
    logic                 out_free;
    logic [POS_W-1:0]     half_cl;
    logic [POS_W-1:0]     ent_base;
    logic [POS_W-1:0]     rd_pos0;
    logic [POS_W-1:0]     rd_pos1;
    logic                 pos0_ok;
    logic                 pos1_ok;
    logic                 walk_err;
    logic [CLUSTER_W-1:0] cl_m2;
    logic [CHUNK_W-1:0]   len_min;
    logic [POS_W-1:0]     wr_pos;
    logic                 ram_we;
    logic                 ram_re;
    logic [POS_W-1:0]     rd_pos;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [BYTE_W-1:0]    byte0;
    logic [BYTE_W-1:0]    byte1;
    logic [CLUSTER_W-1:0] next_cl;
    logic                 chunk_last;

    assign in_fire  = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_chunk.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    assign half_cl  = POS_W'(r_cur_cluster[CLUSTER_W-1:1]);
    assign ent_base = (half_cl << 1) + half_cl;
    assign rd_pos0  = ent_base + POS_W'(r_cur_cluster[0]);
    assign rd_pos1  = rd_pos0 + POS_W'(1);
    assign pos0_ok  = (14'(rd_pos0) < 14'(FAT_SIZE_BYTES));
    assign pos1_ok  = (14'(rd_pos1) < 14'(FAT_SIZE_BYTES));
    assign walk_err = (r_cur_cluster < CLUSTER_W'(2)) || (ent_base > r_fat_bytes);
    assign cl_m2    = r_cur_cluster - CLUSTER_W'(2);
    assign len_min  = (r_bytes_left > LEN_W'(r_cluster_bytes)) ? r_cluster_bytes
                                                              : r_bytes_left[CHUNK_W-1:0];

    assign wr_pos = POS_W'(i_cmd.fat_index);
    assign ram_we = in_fire && (i_cmd.kind == KIND_FAT_WRITE)
                    && (14'(i_cmd.fat_index) < 14'(FAT_SIZE_BYTES));
    assign ram_re = ((r_state == S_FETCH0) && !walk_err && pos0_ok)
                    || ((r_state == S_FETCH1) && pos1_ok);
    assign rd_pos = (r_state == S_FETCH0) ? rd_pos0 : rd_pos1;

    fcw_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FAT_SIZE_BYTES)
    ) u_fat_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(wr_pos[AW-1:0]),
        .i_wdata(i_cmd.fat_byte),
        .i_re   (ram_re),
        .i_raddr(rd_pos[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Even entries take the low twelve bits of the byte pair, odd entries the high twelve.
    assign byte0   = r_zero0 ? '0 : r_byte0;
    assign byte1   = r_zero1 ? '0 : ram_rdata;
    assign next_cl = r_cur_cluster[0] ? {byte1, byte0[7:4]} : {byte1[3:0], byte0};
    assign chunk_last = (r_bytes_left == LEN_W'(r_len));

    always_comb begin
        n_state       = r_state;
        n_walk_active = r_walk_active;
        n_out_valid   = r_out_valid;
        n_cur_cluster = r_cur_cluster;
        n_bytes_left  = r_bytes_left;
        n_done_bytes  = r_done_bytes;
        n_rtype       = r_rtype;
        if (r_out_valid && o_chunk.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_cmd.kind)
                        KIND_START: begin
                            n_cur_cluster = i_cmd.start_cluster;
                            n_bytes_left  = i_cmd.file_length;
                            n_done_bytes  = '0;
                            if (i_cmd.file_length == '0) begin
                                n_walk_active = 1'b0;
                                n_rtype       = RT_EMPTY;
                                n_state       = S_EMIT;
                            end else begin
                                n_walk_active = 1'b1;
                                n_rtype       = RT_CHUNK;
                                n_state       = S_FETCH0;
                            end
                        end
                        KIND_NEXT: begin
                            if (r_walk_active) begin
                                n_rtype = RT_CHUNK;
                                n_state = S_FETCH0;
                            end else begin
                                n_rtype = RT_ERROR;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH0: begin
                if (walk_err) begin
                    n_rtype = RT_ERROR;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FETCH1;
                end
            end
            S_FETCH1: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    case (r_rtype)
                        RT_CHUNK: begin
                            n_cur_cluster = next_cl;
                            n_done_bytes  = r_done_bytes + LEN_W'(r_len);
                            n_bytes_left  = r_bytes_left - LEN_W'(r_len);
                            n_walk_active = !chunk_last;
                        end
                        RT_ERROR: begin
                            n_walk_active = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_walk_active   <= 1'b0;
            r_out_valid     <= 1'b0;
            r_cur_cluster   <= '0;
            r_bytes_left    <= '0;
            r_done_bytes    <= '0;
            r_cluster_bytes <= RST_CLUSTER_BYTES;
            r_fat_bytes     <= RST_FAT_BYTES;
            r_data_base     <= RST_DATA_BASE;
        end else begin
            r_state       <= n_state;
            r_walk_active <= n_walk_active;
            r_out_valid   <= n_out_valid;
            r_cur_cluster <= n_cur_cluster;
            r_bytes_left  <= n_bytes_left;
            r_done_bytes  <= n_done_bytes;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLUSTER_BYTES: r_cluster_bytes <= i_cfg_data[CHUNK_W-1:0];
                    CFG_FAT_BYTES:     r_fat_bytes     <= i_cfg_data[FAT_BYTES_W-1:0];
                    CFG_DATA_BASE:     r_data_base     <= i_cfg_data[BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rtype <= n_rtype;
        if (r_state == S_FETCH0) begin
            r_prod  <= ADDR_W'({16'b0, cl_m2} * {12'b0, r_cluster_bytes});
            r_len   <= len_min;
            r_zero0 <= !pos0_ok;
        end
        if (r_state == S_FETCH1) begin
            r_byte0 <= ram_rdata;
            r_addr  <= ADDR_W'(r_data_base) + r_prod;
            r_zero1 <= !pos1_ok;
        end
        if ((r_state == S_EMIT) && out_free) begin
            case (r_rtype)
                RT_CHUNK: begin
                    r_o_addr  <= r_addr;
                    r_o_len   <= r_len;
                    r_o_off   <= r_done_bytes;
                    r_o_last  <= chunk_last;
                    r_o_error <= 1'b0;
                end
                RT_EMPTY: begin
                    r_o_addr  <= '0;
                    r_o_len   <= '0;
                    r_o_off   <= '0;
                    r_o_last  <= 1'b1;
                    r_o_error <= 1'b0;
                end
                default: begin
                    r_o_addr  <= '0;
                    r_o_len   <= '0;
                    r_o_off   <= '0;
                    r_o_last  <= 1'b0;
                    r_o_error <= 1'b1;
                end
            endcase
        end
    end

    assign o_chunk.valid       = r_out_valid;
    assign o_chunk.image_addr  = r_o_addr;
    assign o_chunk.chunk_len   = r_o_len;
    assign o_chunk.file_offset = r_o_off;
    assign o_chunk.last        = r_o_last;
    assign o_chunk.error       = r_o_error;
endmodule

// ===== hdl/fcw_checker.sv =====
// Port-level checks for the FAT12 cluster chain walker, bound to its top level.
// Depends on fcw_pkg and on the top level's chunk channel.
module fcw_checker import fcw_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [ADDR_W-1:0]  i_addr,
    input logic [CHUNK_W-1:0] i_len,
    input logic [LEN_W-1:0]   i_off,
    input logic               i_last,
    input logic               i_err
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("Result transaction shown right after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_addr) && $stable(i_len)
            && $stable(i_off) && $stable(i_last) && $stable(i_err))
        else $error("Stalled result transaction changed.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_err |-> i_addr == '0 && i_len == '0 && i_off == '0 && !i_last)
        else $error("Error result carries chunk data.");

    a_last_or_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_last && i_err))
        else $error("Result marked both last and error.");
endmodule

bind fat12_cluster_chain_walker_unit fcw_checker u_fcw_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_chunk.valid),
    .i_ready(o_chunk.ready),
    .i_addr (o_chunk.image_addr),
    .i_len  (o_chunk.chunk_len),
    .i_off  (o_chunk.file_offset),
    .i_last (o_chunk.last),
    .i_err  (o_chunk.error)
);

// ===== bench/fcw_chunk_checker.sv =====
`timescale 1ns / 100ps
// Checker for the FAT12 cluster chain walker: watches the command, chunk and register
// ports, predicts every chunk from its own copy of the table and walk state, and compares.
// Depends on fcw_pkg, fcw_cmd_if and fcw_chunk_if.
module fcw_chunk_checker import fcw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fcw_cmd_if                    i_cmd,
    fcw_chunk_if                  i_chunk,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0]  image_addr;
        logic [CHUNK_W-1:0] chunk_len;
        logic [LEN_W-1:0]   file_offset;
        logic               last;
        logic               error;
    } t_chunk;

    logic [BYTE_W-1:0]      fat_copy [FCW_FAT_SIZE_BYTES];
    logic [CLUSTER_W-1:0]   cur_cluster;
    logic [LEN_W-1:0]       bytes_left;
    logic [LEN_W-1:0]       bytes_done;
    logic                   walk_on;
    logic [CHUNK_W-1:0]     cl_bytes;
    logic [FAT_BYTES_W-1:0] fat_limit;
    logic [BASE_W-1:0]      base_addr;
    t_chunk                 chunks_due [$];
    int                     fails = 0;

    function automatic logic [BYTE_W-1:0] table_byte(input int unsigned pos);
        if (pos >= FCW_FAT_SIZE_BYTES) begin
            return '0;
        end
        return fat_copy[pos];
    endfunction

    function automatic logic [CLUSTER_W-1:0] link_of(input logic [CLUSTER_W-1:0] cl);
        int unsigned pos;
        logic [23:0] triple;
        pos = int'(cl[CLUSTER_W-1:1]) * 3;
        triple = {table_byte(pos + 2), table_byte(pos + 1), table_byte(pos)};
        return cl[0] ? triple[23:12] : triple[11:0];
    endfunction

    function automatic t_chunk walk_one_cluster();
        t_chunk      r;
        int unsigned pos;
        logic [31:0] len;
        logic [31:0] addr;
        r = '0;
        pos = int'(cur_cluster[CLUSTER_W-1:1]) * 3;
        if (cur_cluster < 2 || pos > fat_limit) begin
            walk_on = 1'b0;
            r.error = 1'b1;
            return r;
        end
        len = (bytes_left > 32'(cl_bytes)) ? 32'(cl_bytes) : bytes_left;
        addr = 32'(base_addr) + 32'(cur_cluster - 12'd2) * 32'(cl_bytes);
        r.image_addr = addr[ADDR_W-1:0];
        r.chunk_len = len[CHUNK_W-1:0];
        r.file_offset = bytes_done;
        cur_cluster = link_of(cur_cluster);
        bytes_done = bytes_done + len;
        bytes_left = bytes_left - len;
        if (bytes_left == 0) begin
            walk_on = 1'b0;
            r.last = 1'b1;
        end
        return r;
    endfunction

    task automatic report_chunk(input string what, input t_chunk want, input t_chunk got);
        fails++;
        if (fails <= 10) begin
            $display("%s: expected addr %h len %0d offset %0d last %b error %b, got addr %h len %0d offset %0d last %b error %b",
                     what, want.image_addr, want.chunk_len, want.file_offset, want.last,
                     want.error, got.image_addr, got.chunk_len, got.file_offset, got.last,
                     got.error);
        end
    endtask

    always @(posedge i_clk) begin
        t_chunk want;
        t_chunk got;
        if (!i_rst_n) begin
            cur_cluster = '0;
            bytes_left = '0;
            bytes_done = '0;
            walk_on = 1'b0;
            cl_bytes = RST_CLUSTER_BYTES;
            fat_limit = RST_FAT_BYTES;
            base_addr = RST_DATA_BASE;
            chunks_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLUSTER_BYTES: cl_bytes = i_cfg_data[CHUNK_W-1:0];
                    CFG_FAT_BYTES:     fat_limit = i_cfg_data[FAT_BYTES_W-1:0];
                    CFG_DATA_BASE:     base_addr = i_cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
            // A chunk leaving at this edge always belongs to an older command transaction.
            if (i_chunk.valid && i_chunk.ready) begin
                got = {i_chunk.image_addr, i_chunk.chunk_len, i_chunk.file_offset,
                       i_chunk.last, i_chunk.error};
                if (chunks_due.size() == 0) begin
                    report_chunk("chunk with nothing expected", '0, got);
                end else begin
                    want = chunks_due.pop_front();
                    if (got.image_addr !== want.image_addr || got.chunk_len !== want.chunk_len ||
                        got.file_offset !== want.file_offset || got.last !== want.last ||
                        got.error !== want.error) begin
                        report_chunk("chunk mismatch", want, got);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.kind)
                    KIND_FAT_WRITE: fat_copy[i_cmd.fat_index] = i_cmd.fat_byte;
                    KIND_START: begin
                        cur_cluster = i_cmd.start_cluster;
                        bytes_left = i_cmd.file_length;
                        bytes_done = '0;
                        if (i_cmd.file_length == 0) begin
                            walk_on = 1'b0;
                            want = '0;
                            want.last = 1'b1;
                            chunks_due.push_back(want);
                        end else begin
                            walk_on = 1'b1;
                            chunks_due.push_back(walk_one_cluster());
                        end
                    end
                    KIND_NEXT: begin
                        if (walk_on) begin
                            chunks_due.push_back(walk_one_cluster());
                        end else begin
                            want = '0;
                            want.error = 1'b1;
                            chunks_due.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= chunks_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_fat12_cluster_chain_walker_unit.sv =====
`timescale 1ns / 100ps
// Top of the FAT12 cluster chain walker bench: clock, reset, register writes, command
// stimulus and chunk back-pressure; fcw_chunk_checker predicts and compares.
// Depends on fcw_pkg, fcw_cmd_if, fcw_chunk_if, fcw_chunk_checker and the block itself.
module tb_fat12_cluster_chain_walker_unit;
    import fcw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    // The table size register never exceeds FAT_LIMIT, so walks only read loaded bytes.
    localparam int FAT_LIMIT = 513;
    localparam int FAT_LOAD = FAT_LIMIT + 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    hold_requests = 0;
    int                    burst_left = 0;
    logic                  valid_up = 1'b0;
    int unsigned           cur_cb;
    int unsigned           cur_fb;
    logic [BYTE_W-1:0]     fat_image [FCW_FAT_SIZE_BYTES];

    fcw_cmd_if   cmd_ch ();
    fcw_chunk_if chunk_ch ();

    fat12_cluster_chain_walker_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_chunk    (chunk_ch)
    );

    fcw_chunk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd_ch),
        .i_chunk      (chunk_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : chunk_sink
        int hold_left;
        int mode;
        int mode_left;
        int served;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        served = 0;
        chunk_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                chunk_ch.ready <= 1'b0;
                hold_left--;
            end else if (served != hold_requests) begin
                served = hold_requests;
                hold_left = 300;
                chunk_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0: chunk_ch.ready <= 1'b1;
                    1: chunk_ch.ready <= 1'($urandom_range(0, 1));
                    2: chunk_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: chunk_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic logic [CLUSTER_W-1:0] random_link();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            return CLUSTER_W'($urandom_range(2, 340));
        end else if (pick < 90) begin
            return 12'hfff;
        end else if (pick < 95) begin
            return CLUSTER_W'($urandom_range(0, 1));
        end
        return CLUSTER_W'($urandom);
    endfunction

    task automatic send_cmd(input logic [KIND_W-1:0] kind, input int unsigned idx,
                            input int unsigned value,
                            input int unsigned cluster,
                            input logic [LEN_W-1:0] length);
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.fat_index <= FAT_IDX_W'(idx);
        cmd_ch.fat_byte <= BYTE_W'(value);
        cmd_ch.start_cluster <= CLUSTER_W'(cluster);
        cmd_ch.file_length <= length;
        valid_up = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (burst_left == 0) begin
            cmd_ch.valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        if (valid_up) begin
            cmd_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(input int unsigned cb, input int unsigned fb,
                              input int unsigned db);
        cur_cb = cb;
        cur_fb = fb;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_CLUSTER_BYTES;
        i_cfg_data <= CFG_DATA_W'(cb);
        @(posedge i_clk);
        i_cfg_idx <= CFG_FAT_BYTES;
        i_cfg_data <= CFG_DATA_W'(fb);
        @(posedge i_clk);
        i_cfg_idx <= CFG_DATA_BASE;
        i_cfg_data <= CFG_DATA_W'(db);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_traffic(input int n_items);
        int               sent;
        int               pick;
        int               n_next;
        int unsigned      max_cl;
        int unsigned      cl;
        logic [LEN_W-1:0] len;
        sent = 0;
        max_cl = (cur_fb < 3) ? 3 : (cur_fb / 3) * 2 + 1;
        if (max_cl > 4095) begin
            max_cl = 4095;
        end
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 99) < 85) begin
                    cl = $urandom_range(2, max_cl);
                end else begin
                    cl = $urandom;
                end
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(1, cur_cb * 4);
                    1: len = cur_cb * $urandom_range(1, 4);
                    2: len = $urandom_range(1, cur_cb);
                    default: len = $urandom;
                endcase
                send_cmd(KIND_START, $urandom, $urandom, cl, len);
                n_next = $urandom_range(0, 6);
                sent += 1 + n_next;
                repeat (n_next) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_cmd(KIND_FAT_WRITE, $urandom, $urandom, $urandom, $urandom);
                        sent++;
                    end
                    send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
                end
            end else if (pick < 80) begin
                send_cmd(KIND_FAT_WRITE, $urandom, $urandom, $urandom, $urandom);
                sent++;
            end else if (pick < 88) begin
                send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
                sent++;
            end else if (pick < 93) begin
                send_cmd(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_cmd(KIND_START, $urandom, $urandom, $urandom, '0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [CLUSTER_W-1:0] e0;
        logic [CLUSTER_W-1:0] e1;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind <= KIND_FAT_WRITE;
        cmd_ch.fat_index <= '0;
        cmd_ch.fat_byte <= '0;
        cmd_ch.start_cluster <= '0;
        cmd_ch.file_length <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_CLUSTER_BYTES;
        i_cfg_data <= '0;
        cur_cb = 32'(RST_CLUSTER_BYTES);
        cur_fb = 32'(RST_FAT_BYTES);

        for (int p = 0; p < FCW_FAT_SIZE_BYTES / 3; p++) begin
            e0 = random_link();
            e1 = random_link();
            fat_image[3 * p] = e0[7:0];
            fat_image[3 * p + 1] = {e1[3:0], e0[11:8]};
            fat_image[3 * p + 2] = e1[11:4];
        end
        fat_image[0] = 8'hff;
        fat_image[FCW_FAT_SIZE_BYTES - 1] = 8'h00;
        // Clusters 2, 3 and 4 form a fixed three-cluster chain ending in an end mark.
        fat_image[3] = 8'h03;
        fat_image[4] = 8'h40;
        fat_image[5] = 8'h00;
        fat_image[6] = 8'hff;
        fat_image[7][3:0] = 4'hf;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // These cases never touch the table, so they run before it is loaded.
        send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
        send_cmd(KIND_START, $urandom, $urandom, 0, 32'd100);
        send_cmd(KIND_START, $urandom, $urandom, 1, 32'hffff_ffff);
        send_cmd(KIND_START, $urandom, $urandom, 'hfff, 32'd1);
        send_cmd(KIND_START, $urandom, $urandom, 5, 32'd0);
        send_cmd(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);

        for (int i = 0; i < FAT_LOAD; i++) begin
            send_cmd(KIND_FAT_WRITE, i, 32'(fat_image[i]), $urandom, $urandom);
        end

        send_cmd(KIND_START, $urandom, $urandom, 2, 32'd5000);
        repeat (4) send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
        send_cmd(KIND_START, $urandom, $urandom, 2, 32'hffff_ffff);
        send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
        send_cmd(KIND_START, $urandom, $urandom, 3, 32'd2048);
        send_cmd(KIND_START, $urandom, $urandom, 2, 32'd10000);
        send_cmd(KIND_FAT_WRITE, 4, 0, $urandom, $urandom);
        send_cmd(KIND_FAT_WRITE, 5, 1, $urandom, $urandom);
        repeat (2) send_cmd(KIND_NEXT, $urandom, $urandom, $urandom, $urandom);
        send_cmd(KIND_START, $urandom, $urandom, 341, 32'd700);
        send_cmd(KIND_START, $urandom, $urandom, 342, 32'd700);
        run_traffic(32);

        wait_idle();
        write_regs(128, FAT_LIMIT, 0);
        hold_requests <= hold_requests + 1;
        run_traffic(32);

        wait_idle();
        write_regs(32768, FAT_LIMIT, 24'hff_ffff);
        send_cmd(KIND_START, $urandom, $urandom, 343, 32'hffff_ffff);
        send_cmd(KIND_START, $urandom, $urandom, 344, 32'hffff_ffff);
        run_traffic(32);

        wait_idle();
        write_regs($urandom_range(128, 32768), 0, $urandom_range(0, 24'hff_ffff));
        hold_requests <= hold_requests + 1;
        run_traffic(32);

        wait_idle();
        write_regs(512, $urandom_range(0, FAT_LIMIT), $urandom_range(0, 24'hff_ffff));
        run_traffic(32);

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
